// ===== design/pgf_pkg.sv =====
`timescale 1ns / 1ps

package pgf_pkg;

  // fixed field widths
  localparam int GRID_W      = 11;
  localparam int EXT_FIELD_W = 16;
  localparam int CFG_IDX_W   = 2;

  // defaults for the top-level parameters
  localparam int DEF_MAX_PROCS   = 1024;
  localparam int DEF_EXTENT_BITS = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USER_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USER_GRID_Z = 2'd2;

  typedef logic [GRID_W-1:0] grid_t;

  typedef struct packed {
    logic  start;
    grid_t dividend;
    grid_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    grid_t quot;
    grid_t rem;
  } div_resp_t;

endpackage

// ===== design/pgf_div.sv =====
`timescale 1ns / 1ps

module pgf_div import pgf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  div_req_t  req,
  output div_resp_t resp
);

  localparam int CNT_W = $clog2(GRID_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(GRID_W - 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  grid_t            rem;
  grid_t            quo;
  grid_t            dsr;

  logic [GRID_W:0] trial;
  logic            qbit;
  grid_t           rem_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem, quo[GRID_W-1]};
    qbit     = (trial >= {1'b0, dsr});
    rem_next = qbit ? GRID_W'(trial - {1'b0, dsr}) : GRID_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[GRID_W-2:0], qbit};
    end
  end

  assign resp.done = done;
  assign resp.quot = quo;
  assign resp.rem  = rem;

endmodule

// ===== design/pgf_mul.sv =====
`timescale 1ns / 1ps

module pgf_mul import pgf_pkg::*; #(
  parameter int A_W = 2 * DEF_EXTENT_BITS,
  parameter int B_W = DEF_EXTENT_BITS
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  // product registered, ready in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= (A_W + B_W)'(a) * (A_W + B_W)'(b);
  end

endmodule

// ===== design/processor_grid_factorizer_core.sv =====
`timescale 1ns / 1ps

// Processor grid factorizer. One transfer on the input channel carries a
// process count, a 2D/3D mode and three domain extents; the block walks every
// factorization px*py(*pz) = num_procs with px ascending, then py ascending,
// skips those that break a nonzero pin in user_grid_x/y/z, and returns the
// candidate with the least per-process boundary (ties keep the first one),
// or found = 0 with all grid fields zero. One item is worked at a time and
// in_ready is low while it runs. Every divisibility test goes through one
// shared restoring divider, and costs go through one shared registered
// multiplier, with a set-up in 3D that forms the pairwise extent products.
// A finished result sits in the output register until taken, and the next
// item may be accepted meanwhile. Pins are to be written through cfg_we
// only while the block is idle; the block itself does not enforce this.
module processor_grid_factorizer_core import pgf_pkg::*; #(
  parameter int MAX_PROCS   = DEF_MAX_PROCS,
  parameter int EXTENT_BITS = DEF_EXTENT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [GRID_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [GRID_W-1:0]      num_procs,
  input  logic [EXT_FIELD_W-1:0] extent_x,
  input  logic [EXT_FIELD_W-1:0] extent_y,
  input  logic [EXT_FIELD_W-1:0] extent_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [GRID_W-1:0]      grid_x,
  output logic [GRID_W-1:0]      grid_y,
  output logic [GRID_W-1:0]      grid_z
);

  // extents are used in their low bits only, never beyond the field
  localparam int EW     = (EXTENT_BITS < EXT_FIELD_W) ? EXTENT_BITS : EXT_FIELD_W;
  localparam int AW     = 2 * EW;
  localparam int BW     = (EW > GRID_W) ? EW : GRID_W;
  localparam int PW     = AW + BW;
  // three terms, each below 2^(2*EW) * 2^GRID_W
  localparam int COST_W = 2 * EW + GRID_W + 2;
  localparam logic [31:0] MAXP = 32'(MAX_PROCS);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PRE_XY = 5'd1;
  localparam logic [4:0] S_PRE_XZ = 5'd2;
  localparam logic [4:0] S_PRE_YZ = 5'd3;
  localparam logic [4:0] S_PRE_END = 5'd4;
  localparam logic [4:0] S_DIVX   = 5'd5;
  localparam logic [4:0] S_WAITX  = 5'd6;
  localparam logic [4:0] S_NEXTX  = 5'd7;
  localparam logic [4:0] S_C2A    = 5'd8;
  localparam logic [4:0] S_C2B    = 5'd9;
  localparam logic [4:0] S_C2C    = 5'd10;
  localparam logic [4:0] S_DIVY   = 5'd11;
  localparam logic [4:0] S_WAITY  = 5'd12;
  localparam logic [4:0] S_NEXTY  = 5'd13;
  localparam logic [4:0] S_C3A    = 5'd14;
  localparam logic [4:0] S_C3B    = 5'd15;
  localparam logic [4:0] S_C3C    = 5'd16;
  localparam logic [4:0] S_C3D    = 5'd17;
  localparam logic [4:0] S_FINISH = 5'd18;

  // pin registers
  grid_t user_grid_x;
  grid_t user_grid_y;
  grid_t user_grid_z;

  // working registers of the current item
  logic [4:0]    state;
  logic          mode;
  grid_t         n;
  logic [EW-1:0] ex;
  logic [EW-1:0] ey;
  logic [EW-1:0] ez;
  logic [AW-1:0] axy;
  logic [AW-1:0] axz;
  logic [AW-1:0] ayz;
  grid_t         px;
  grid_t         py;
  grid_t         pz;
  grid_t         remq;
  logic [COST_W-1:0] acc;
  logic [COST_W-1:0] best;
  logic          have;
  grid_t         bx;
  grid_t         by;
  grid_t         bz;

  // shared units
  div_req_t      div_req;
  div_resp_t     div_resp;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  logic [COST_W-1:0] cost;
  logic              better;
  logic              n_bad;
  logic              pin_x_bad;
  logic              pin_y2_bad;
  logic              pin_y3_bad;
  logic              pin_z3_bad;
  logic              out_load;

  pgf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  pgf_mul #(
    .A_W (AW),
    .B_W (BW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // pin writes, ignored beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      user_grid_x <= '0;
      user_grid_y <= '0;
      user_grid_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USER_GRID_X: user_grid_x <= cfg_data;
        REG_USER_GRID_Y: user_grid_y <= cfg_data;
        REG_USER_GRID_Z: user_grid_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign n_bad    = (num_procs == '0) || (32'(num_procs) > MAXP);

  // result moves into the output register once that register is free
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  // divider request: px against the count, py against the remaining factor
  always_comb begin
    div_req.start    = (state == S_DIVX) || (state == S_DIVY);
    div_req.dividend = (state == S_DIVX) ? n : remq;
    div_req.divisor  = (state == S_DIVX) ? px : py;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PRE_XY: begin
        mul_a = AW'(ex);
        mul_b = BW'(ey);
      end
      S_PRE_XZ: begin
        mul_a = AW'(ex);
        mul_b = BW'(ez);
      end
      S_PRE_YZ: begin
        mul_a = AW'(ey);
        mul_b = BW'(ez);
      end
      S_C2A: begin
        mul_a = AW'(ex);
        mul_b = BW'(py);
      end
      S_C2B: begin
        mul_a = AW'(ey);
        mul_b = BW'(px);
      end
      S_C3A: begin
        mul_a = axy;
        mul_b = BW'(pz);
      end
      S_C3B: begin
        mul_a = axz;
        mul_b = BW'(py);
      end
      S_C3C: begin
        mul_a = ayz;
        mul_b = BW'(px);
      end
      default: ;
    endcase
  end

  // last term plus running sum; only a strictly smaller cost wins
  assign cost   = acc + COST_W'(mul_p);
  assign better = !have || (cost < best);

  assign pin_x_bad  = (user_grid_x != '0) && (user_grid_x != px);
  assign pin_y2_bad = (user_grid_y != '0) && (user_grid_y != div_resp.quot);
  assign pin_y3_bad = (user_grid_y != '0) && (user_grid_y != py);
  assign pin_z3_bad = (user_grid_z != '0) && (user_grid_z != div_resp.quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode <= action;
            n    <= num_procs;
            ex   <= extent_x[EW-1:0];
            ey   <= extent_y[EW-1:0];
            ez   <= extent_z[EW-1:0];
            have <= 1'b0;
            px   <= GRID_W'(1);
            if (n_bad) begin
              state <= S_FINISH;
            end else if (action) begin
              state <= S_PRE_XY;
            end else begin
              state <= S_DIVX;
            end
          end
        end
        // 3D set-up: pairwise extent products
        S_PRE_XY: state <= S_PRE_XZ;
        S_PRE_XZ: begin
          axy   <= AW'(mul_p);
          state <= S_PRE_YZ;
        end
        S_PRE_YZ: begin
          axz   <= AW'(mul_p);
          state <= S_PRE_END;
        end
        S_PRE_END: begin
          ayz   <= AW'(mul_p);
          state <= S_DIVX;
        end
        // outer loop over px
        S_DIVX: state <= S_WAITX;
        S_WAITX: begin
          if (div_resp.done) begin
            remq <= div_resp.quot;
            if ((div_resp.rem != '0) || pin_x_bad) begin
              state <= S_NEXTX;
            end else if (!mode) begin
              py <= div_resp.quot;
              pz <= GRID_W'(1);
              state <= pin_y2_bad ? S_NEXTX : S_C2A;
            end else begin
              py    <= GRID_W'(1);
              state <= S_DIVY;
            end
          end
        end
        S_NEXTX: begin
          if (px == n) begin
            state <= S_FINISH;
          end else begin
            px    <= px + 1'b1;
            state <= S_DIVX;
          end
        end
        // 2D cost ex*py + ey*px
        S_C2A: state <= S_C2B;
        S_C2B: begin
          acc   <= COST_W'(mul_p);
          state <= S_C2C;
        end
        S_C2C: begin
          if (better) begin
            have <= 1'b1;
            best <= cost;
            bx   <= px;
            by   <= py;
            bz   <= pz;
          end
          state <= S_NEXTX;
        end
        // inner loop over py in 3D
        S_DIVY: state <= S_WAITY;
        S_WAITY: begin
          if (div_resp.done) begin
            pz <= div_resp.quot;
            if ((div_resp.rem != '0) || pin_y3_bad || pin_z3_bad) begin
              state <= S_NEXTY;
            end else begin
              state <= S_C3A;
            end
          end
        end
        S_NEXTY: begin
          if (py == remq) begin
            state <= S_NEXTX;
          end else begin
            py    <= py + 1'b1;
            state <= S_DIVY;
          end
        end
        // 3D cost axy*pz + axz*py + ayz*px
        S_C3A: state <= S_C3B;
        S_C3B: begin
          acc   <= COST_W'(mul_p);
          state <= S_C3C;
        end
        S_C3C: begin
          acc   <= cost;
          state <= S_C3D;
        end
        S_C3D: begin
          if (better) begin
            have <= 1'b1;
            best <= cost;
            bx   <= px;
            by   <= py;
            bz   <= pz;
          end
          state <= S_NEXTY;
        end
        // hand the result to the output register once it is free
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output payload, loaded with the transfer into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      found  <= have;
      grid_x <= have ? bx : '0;
      grid_y <= have ? by : '0;
      grid_z <= have ? bz : '0;
    end
  end

  // a miss reports all grid fields zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (grid_x == '0) && (grid_y == '0) && (grid_z == '0))
    else $error("not-found result with nonzero grid");

  // a hit has no zero dimension
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (grid_x != '0) && (grid_y != '0) && (grid_z != '0))
    else $error("found result with zero dimension");

  // the kept candidate really factors the count
  a_best_factors: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && have) |->
      ((33'(bx) * 33'(by) * 33'(bz)) == 33'(n)))
    else $error("best candidate does not factor the count");

  // the outer loop stays within 1..n
  a_px_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVX) |-> (px != '0) && (px <= n))
    else $error("px out of range");

endmodule
